// ===== hdl/bfp_pkg.sv =====
package bfp_pkg;

   localparam int unsigned CellW = 24;
   localparam int unsigned HandleW = 5;
   localparam int unsigned SizeW = 33;
   localparam int unsigned TotalW = 39;
   localparam logic [8:0] CellBytes = 9'd392;
   localparam logic [9:0] FixedBytes = 10'd864;

   typedef enum logic [1:0] {
      REQ_ACQUIRE = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      KIND_REUSED  = 3'd0,
      KIND_NEW     = 3'd1,
      KIND_RELEASE = 3'd2,
      KIND_EVICT   = 3'd3,
      KIND_CLEAR   = 3'd4,
      KIND_FULL    = 3'd5,
      KIND_BAD     = 3'd6
   } rsp_kind_type;

   typedef struct packed {
      req_kind_type          req_type;
      logic [CellW-1:0]      min_cells;
      logic [HandleW-1:0]    handle;
   } cmd_type;

   typedef struct packed {
      rsp_kind_type          kind;
      logic [HandleW-1:0]    handle_out;
      logic [CellW-1:0]      cells;
      logic [SizeW-1:0]      size_bytes;
      logic [TotalW-1:0]     free_bytes;
      logic                  last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_EMIT,
      ST_EVICT_CHECK,
      ST_EVICT_MUL,
      ST_EVICT_EMIT
   } state_type;

endpackage

// ===== hdl/bfp_req_if.sv =====
interface bfp_req_if;
   import bfp_pkg::*;
   logic    valid;
   logic    ready;
   cmd_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/bfp_rsp_if.sv =====
interface bfp_rsp_if;
   import bfp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/best_fit_pool_with_byte_limit_eviction_core.sv =====
// channel  | dir | transfer payload
// req      | in  | req_type, min_cells, handle
// rsp      | out | kind, handle_out, cells, size_bytes, free_bytes, last
// csr      | in  | byte_limit write
// acquire: free-list scan of one entry per cycle, then the size multiply and the response
// release: multiply and response, then check, multiply and response per evicted entry; clear: multiply and response
// requests pass through a two-entry queue; a held output stalls the back end
// reset clears the table flags, counts and byte total at once
module best_fit_pool_with_byte_limit_eviction_core #(
   parameter int unsigned HANDLE_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   bfp_req_if.sink     req,
   bfp_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [38:0] csr_wdata
);
   import bfp_pkg::*;

   logic [TotalW-1:0] limit_ff;
   logic              cmd_valid, cmd_pop;
   cmd_type           cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TotalW'(67108864);
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   bfp_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
   );

   bfp_back #(.HANDLE_SLOTS(HANDLE_SLOTS)) u_back (
      .clock(clock), .reset(reset), .byte_limit(limit_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .rsp(rsp)
   );
endmodule

// ===== hdl/bfp_front.sv =====
module bfp_front (
   input  logic         clock,
   input  logic         reset,
   bfp_req_if.sink      req,
   output logic         cmd_valid,
   output bfp_pkg::cmd_type cmd,
   input  logic         cmd_pop
);
   import bfp_pkg::*;

   // two-entry queue, REQ_NONE requests dropped here
   cmd_type    q_ff [2];
   cmd_type    q0_in, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready && (req.payload.req_type != REQ_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[0];

   always_comb begin
      cnt_in = cnt_ff;
      q0_in = q_ff[0];
      q1_in = q_ff[1];
      if (cmd_pop) begin
         q0_in = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) begin
            q0_in = req.payload;
         end else begin
            q1_in = req.payload;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end
endmodule

// ===== hdl/bfp_back.sv =====
module bfp_back #(
   parameter int unsigned HANDLE_SLOTS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [38:0]  byte_limit,
   input  logic         cmd_valid,
   input  bfp_pkg::cmd_type cmd,
   output logic         cmd_pop,
   bfp_rsp_if.source    rsp
);
   import bfp_pkg::*;

   localparam int unsigned UseSlots = (HANDLE_SLOTS < 32) ? HANDLE_SLOTS : 32;
   localparam int unsigned CntW = $clog2(UseSlots + 1);
   localparam int unsigned PosW = (UseSlots > 1) ? $clog2(UseSlots) : 1;

   function automatic logic [SizeW-1:0] c_mul(input logic [CellW-1:0] c);
      c_mul = SizeW'(c) * SizeW'(CellBytes) + SizeW'(FixedBytes);
   endfunction

   state_type state_ff, state_in;
   cmd_type   cur_ff;

   logic [UseSlots-1:0] valid_ff, free_ff;
   logic [CellW-1:0]    cells_ff [UseSlots];
   logic [HandleW-1:0]  order_ff [UseSlots];
   logic [CntW-1:0]     fcnt_ff;
   logic [TotalW-1:0]   total_ff;

   logic [CntW-1:0]     pos_ff;
   logic                found_ff;
   logic [PosW-1:0]     bpos_ff;
   logic [HandleW-1:0]  bslot_ff;
   logic [CellW-1:0]    bcells_ff;
   rsp_kind_type        kind_ff;
   logic [HandleW-1:0]  h_ff;
   logic [CellW-1:0]    c_ff;
   logic [SizeW-1:0]    size_ff;
   logic                ovalid_ff;
   rsp_type             out_ff;

   logic [HandleW-1:0]  scan_slot;
   logic [CellW-1:0]    scan_cells;
   logic [HandleW-1:0]  ev_slot;
   logic                hole;
   logic [HandleW-1:0]  hole_slot;
   logic                bad;
   logic                out_free;
   logic                emit;

   assign out_free = !ovalid_ff || rsp.ready;
   assign emit = out_free && (state_ff == ST_EMIT || state_ff == ST_EVICT_EMIT);
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;
   assign scan_slot = order_ff[pos_ff[PosW-1:0]];
   assign scan_cells = cells_ff[scan_slot];
   assign ev_slot = order_ff[0];
   assign bad = (32'(cur_ff.handle) >= UseSlots) || !valid_ff[cur_ff.handle[PosW-1:0]]
      || free_ff[cur_ff.handle[PosW-1:0]];

   always_comb begin
      hole = 1'b0;
      hole_slot = '0;
      for (int i = UseSlots - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            hole = 1'b1;
            hole_slot = HandleW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (cmd_valid) begin
               state_in = (cmd.req_type == REQ_ACQUIRE) ? ST_SCAN : ST_MUL;
            end
         ST_SCAN:
            if (pos_ff == fcnt_ff) begin
               state_in = ST_MUL;
            end
         ST_MUL:
            state_in = ST_EMIT;
         ST_EMIT:
            if (out_free) begin
               state_in = (kind_ff == KIND_RELEASE) ? ST_EVICT_CHECK : ST_IDLE;
            end
         ST_EVICT_CHECK:
            state_in = ST_EVICT_MUL;
         ST_EVICT_MUL:
            state_in = ST_EVICT_EMIT;
         ST_EVICT_EMIT:
            if (out_free) begin
               state_in = ST_EVICT_CHECK;
            end
         default:
            state_in = ST_IDLE;
      endcase
      if (state_ff == ST_EVICT_CHECK && !(total_ff > byte_limit && fcnt_ff != '0)) begin
         state_in = ST_IDLE;
      end
   end

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         free_ff <= '0;
         fcnt_ff <= '0;
         total_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            ovalid_ff <= 1'b1;
         end else if (rsp.ready) begin
            ovalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE:
               if (cmd_valid) begin
                  cur_ff <= cmd;
                  pos_ff <= '0;
                  found_ff <= 1'b0;
               end
            ST_SCAN:
               if (pos_ff != fcnt_ff) begin
                  if (scan_cells >= cur_ff.min_cells &&
                      (!found_ff || scan_cells < bcells_ff)) begin
                     found_ff <= 1'b1;
                     bpos_ff <= pos_ff[PosW-1:0];
                     bslot_ff <= scan_slot;
                     bcells_ff <= scan_cells;
                  end
                  pos_ff <= pos_ff + CntW'(1);
               end
            ST_MUL: begin
               case (cur_ff.req_type)
                  REQ_ACQUIRE:
                     if (found_ff) begin
                        kind_ff <= KIND_REUSED;
                        h_ff <= bslot_ff;
                        c_ff <= bcells_ff;
                        for (int i = 0; i < UseSlots - 1; i++) begin
                           if (i >= bpos_ff) begin
                              order_ff[i] <= order_ff[i + 1];
                           end
                        end
                        fcnt_ff <= fcnt_ff - CntW'(1);
                        free_ff[bslot_ff[PosW-1:0]] <= 1'b0;
                     end else if (hole) begin
                        kind_ff <= KIND_NEW;
                        h_ff <= hole_slot;
                        c_ff <= cur_ff.min_cells;
                        valid_ff[hole_slot[PosW-1:0]] <= 1'b1;
                        free_ff[hole_slot[PosW-1:0]] <= 1'b0;
                        cells_ff[hole_slot[PosW-1:0]] <= cur_ff.min_cells;
                     end else begin
                        kind_ff <= KIND_FULL;
                        h_ff <= '0;
                        c_ff <= cur_ff.min_cells;
                     end
                  REQ_RELEASE:
                     if (bad) begin
                        kind_ff <= KIND_BAD;
                        h_ff <= cur_ff.handle;
                        c_ff <= '0;
                     end else begin
                        kind_ff <= KIND_RELEASE;
                        h_ff <= cur_ff.handle;
                        c_ff <= cells_ff[cur_ff.handle[PosW-1:0]];
                        order_ff[fcnt_ff[PosW-1:0]] <= cur_ff.handle;
                        fcnt_ff <= fcnt_ff + CntW'(1);
                        free_ff[cur_ff.handle[PosW-1:0]] <= 1'b1;
                     end
                  default: begin
                     kind_ff <= KIND_CLEAR;
                     h_ff <= '0;
                     c_ff <= '0;
                     valid_ff <= '0;
                     free_ff <= '0;
                     fcnt_ff <= '0;
                  end
               endcase
               size_ff <= SizeW'(c_mul(cur_ff.req_type == REQ_ACQUIRE && found_ff ?
                  bcells_ff : (cur_ff.req_type == REQ_RELEASE ?
                  cells_ff[cur_ff.handle[PosW-1:0]] : cur_ff.min_cells)));
            end
            ST_EMIT:
               if (out_free) begin
                  out_ff.kind <= kind_ff;
                  out_ff.handle_out <= h_ff;
                  out_ff.cells <= c_ff;
                  out_ff.last <= (kind_ff != KIND_RELEASE) ||
                     !((total_ff + TotalW'(size_ff)) > byte_limit);
                  if (kind_ff == KIND_BAD || kind_ff == KIND_CLEAR) begin
                     out_ff.size_bytes <= '0;
                  end else begin
                     out_ff.size_bytes <= size_ff;
                  end
                  case (kind_ff)
                     KIND_REUSED: begin
                        total_ff <= total_ff - TotalW'(size_ff);
                        out_ff.free_bytes <= total_ff - TotalW'(size_ff);
                     end
                     KIND_RELEASE: begin
                        total_ff <= total_ff + TotalW'(size_ff);
                        out_ff.free_bytes <= total_ff + TotalW'(size_ff);
                     end
                     KIND_CLEAR: begin
                        total_ff <= '0;
                        out_ff.free_bytes <= '0;
                     end
                     default:
                        out_ff.free_bytes <= total_ff;
                  endcase
               end
            ST_EVICT_CHECK:
               if (total_ff > byte_limit && fcnt_ff != '0) begin
                  h_ff <= ev_slot;
                  c_ff <= cells_ff[ev_slot[PosW-1:0]];
                  for (int i = 0; i < UseSlots - 1; i++) begin
                     order_ff[i] <= order_ff[i + 1];
                  end
                  fcnt_ff <= fcnt_ff - CntW'(1);
                  valid_ff[ev_slot[PosW-1:0]] <= 1'b0;
                  free_ff[ev_slot[PosW-1:0]] <= 1'b0;
               end
            ST_EVICT_MUL:
               size_ff <= SizeW'(c_mul(c_ff));
            ST_EVICT_EMIT:
               if (out_free) begin
                  out_ff.kind <= KIND_EVICT;
                  out_ff.handle_out <= h_ff;
                  out_ff.cells <= c_ff;
                  out_ff.size_bytes <= size_ff;
                  out_ff.free_bytes <= total_ff - TotalW'(size_ff);
                  out_ff.last <= !((total_ff - TotalW'(size_ff)) > byte_limit
                     && fcnt_ff != '0);
                  total_ff <= total_ff - TotalW'(size_ff);
               end
            default: begin
            end
         endcase
      end
   end
endmodule

// ===== dv/bfp_checker.sv =====
`timescale 1ns / 1ps
module bfp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bfp_pkg::cmd_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bfp_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [38:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);
   import bfp_pkg::*;

   localparam int Slots = 32;

   logic [38:0]      limit_q;
   logic             used_q [Slots];
   logic             idle_q [Slots];
   logic [CellW-1:0] cap_q [Slots];
   logic [4:0]       fifo_q [$];
   logic [38:0]      idle_bytes_q;
   rsp_type          expected_q [$];

   function automatic logic [SizeW-1:0] bytes_for(logic [CellW-1:0] c);
      logic [SizeW-1:0] r;
      r = SizeW'(c) * 392 + 864;
      return r;
   endfunction

   function automatic rsp_type make_rsp(rsp_kind_type k, logic [4:0] h, logic [CellW-1:0] c);
      rsp_type r;
      r.kind = k;
      r.handle_out = h;
      r.cells = c;
      r.size_bytes = (k == KIND_BAD || k == KIND_CLEAR) ? '0 : bytes_for(c);
      r.free_bytes = idle_bytes_q;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic predict_pool(cmd_type cmd);
      rsp_type out [$];
      int best;
      int pos;
      int s;
      logic [4:0] v;
      best = -1;
      pos = 0;
      case (cmd.req_type)
         REQ_ACQUIRE: begin
            for (int i = 0; i < fifo_q.size(); i++) begin
               s = fifo_q[i];
               if (cap_q[s] >= cmd.min_cells && (best < 0 || cap_q[s] < cap_q[best])) begin
                  best = s;
                  pos = i;
               end
            end
            if (best >= 0) begin
               fifo_q.delete(pos);
               idle_q[best] = 1'b0;
               idle_bytes_q = idle_bytes_q - bytes_for(cap_q[best]);
               out.insert(out.size(), make_rsp(KIND_REUSED, best[4:0], cap_q[best]));
            end else begin
               s = 0;
               while (s < Slots && used_q[s]) s++;
               if (s < Slots) begin
                  used_q[s] = 1'b1;
                  idle_q[s] = 1'b0;
                  cap_q[s] = cmd.min_cells;
                  out.insert(out.size(), make_rsp(KIND_NEW, s[4:0], cmd.min_cells));
               end else begin
                  out.insert(out.size(), make_rsp(KIND_FULL, 5'd0, cmd.min_cells));
               end
            end
         end
         REQ_RELEASE: begin
            if (!used_q[cmd.handle] || idle_q[cmd.handle]) begin
               out.insert(out.size(), make_rsp(KIND_BAD, cmd.handle, '0));
            end else begin
               fifo_q.insert(fifo_q.size(), cmd.handle);
               idle_q[cmd.handle] = 1'b1;
               idle_bytes_q = idle_bytes_q + bytes_for(cap_q[cmd.handle]);
               out.insert(out.size(), make_rsp(KIND_RELEASE, cmd.handle, cap_q[cmd.handle]));
               while (idle_bytes_q > limit_q && fifo_q.size() > 0) begin
                  v = fifo_q.pop_front();
                  idle_bytes_q = idle_bytes_q - bytes_for(cap_q[v]);
                  used_q[v] = 1'b0;
                  idle_q[v] = 1'b0;
                  out.insert(out.size(), make_rsp(KIND_EVICT, v, cap_q[v]));
               end
            end
         end
         REQ_CLEAR: begin
            foreach (used_q[i]) begin
               used_q[i] = 1'b0;
               idle_q[i] = 1'b0;
            end
            fifo_q.delete();
            idle_bytes_q = '0;
            out.insert(out.size(), make_rsp(KIND_CLEAR, 5'd0, '0));
         end
         default: ;
      endcase
      if (out.size() > 0) out[out.size()-1].last = 1'b1;
      foreach (out[i]) expected_q.insert(expected_q.size(), out[i]);
   endtask

   assign pending = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit_q <= 39'd67108864;
         fail_count = 0;
         idle_bytes_q = '0;
         fifo_q.delete();
         expected_q.delete();
         foreach (used_q[i]) begin
            used_q[i] = 1'b0;
            idle_q[i] = 1'b0;
         end
      end else begin
         if (csr_we) limit_q <= csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%t unexpected transfer: actual %p", $time, rsp_payload);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (want !== rsp_payload) begin
                  $display("%t mismatch: expected %p actual %p", $time, want, rsp_payload);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_pool(req_payload);
      end
   end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import bfp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [38:0] csr_wdata = '0;
   logic        rsp_ready = 1'b0;
   logic        hold_off = 1'b0;
   logic        stall_go = 1'b0;
   logic        sending = 1'b1;
   int          fail_count;
   int          pending;

   bfp_req_if req_ch ();
   bfp_rsp_if rsp_ch ();

   best_fit_pool_with_byte_limit_eviction_core uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   assign rsp_ch.ready = rsp_ready;

   bfp_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_payload(rsp_ch.payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #10 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stalls, with a long hold-off phase
   always @(posedge clock) begin
      if (reset || !sending) begin
         rsp_ready <= 1'b1;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      wait (stall_go);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   task automatic send_cmd(req_kind_type t, logic [23:0] c, logic [4:0] h);
      int g;
      cmd_type cmd;
      cmd.req_type = t;
      cmd.min_cells = c;
      cmd.handle = h;
      req_ch.valid <= 1'b1;
      req_ch.payload <= cmd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_limit(logic [38:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [23:0] rand_cells();
      case ($urandom_range(0, 5))
         0: return 24'hFFFFFF;
         1: return 24'd0;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 40));
      endcase
   endfunction

   task automatic random_phase(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) send_cmd(REQ_ACQUIRE, rand_cells(), 5'($urandom));
         else if (r < 93) send_cmd(REQ_RELEASE, 24'($urandom), 5'($urandom_range(0, 12)));
         else if (r < 96) send_cmd(REQ_RELEASE, 24'($urandom), 5'($urandom));
         else if (r < 98) send_cmd(REQ_CLEAR, 24'($urandom), 5'($urandom));
         else send_cmd(REQ_NONE, 24'($urandom), 5'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send_cmd(REQ_RELEASE, 24'd0, 5'd0);
      send_cmd(REQ_ACQUIRE, 24'd10, 5'd0);
      send_cmd(REQ_ACQUIRE, 24'hFFFFFF, 5'd31);
      send_cmd(REQ_ACQUIRE, 24'd10, 5'd0);
      send_cmd(REQ_ACQUIRE, 24'd0, 5'd0);
      send_cmd(REQ_RELEASE, 24'd0, 5'd0);
      send_cmd(REQ_RELEASE, 24'd0, 5'd3);
      send_cmd(REQ_RELEASE, 24'd0, 5'd0);
      send_cmd(REQ_RELEASE, 24'd0, 5'd31);
      send_cmd(REQ_ACQUIRE, 24'd5, 5'd0);
      send_cmd(REQ_NONE, 24'hFFFFFF, 5'd31);
      send_cmd(REQ_RELEASE, 24'd0, 5'd1);
      for (int i = 0; i < 30; i++) send_cmd(REQ_ACQUIRE, 24'(i), 5'd0);
      send_cmd(REQ_ACQUIRE, 24'd7, 5'd0);
      send_cmd(REQ_CLEAR, 24'd0, 5'd0);
      drain_wait();
      write_limit(39'd0);
      send_cmd(REQ_ACQUIRE, 24'd3, 5'd0);
      send_cmd(REQ_RELEASE, 24'd0, 5'd0);
      random_phase(20);
      drain_wait();
      write_limit('1);
      stall_go = 1'b1;
      random_phase(30);
      drain_wait();
      write_limit(39'd20000);
      random_phase(20);
      drain_wait();
      write_limit(39'd67108864);
      random_phase(20);
      drain_wait();
      sending = 1'b0;
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("best_fit_pool_with_byte_limit_eviction_core verification clean");
      else
         $display("best_fit_pool_with_byte_limit_eviction_core verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("best_fit_pool_with_byte_limit_eviction_core verification failed");
      $finish;
   end
endmodule
